[rtl/core/chcf_pkg.sv]
`default_nettype none

package chcf_pkg;

   localparam int ANGLE_BITS_DEFAULT   = 16;
   localparam int CORDIC_STEPS_DEFAULT = 16;

   localparam int XY_W       = 28;
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = 5;
   localparam int CSR_W      = 17;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_W-1:0] ALPHA_RESET = 17'd13107;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECLINATION = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA = 2'd3;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN32 [0:ATAN_DEPTH-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [1:0] {
      MODE_SAMPLE,
      MODE_SET_ZERO,
      MODE_CLEAR_ZERO,
      MODE_LOAD_ZERO
   } chcf_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_ITER,
      ST_ROUND,
      ST_DELTA,
      ST_MUL,
      ST_DONE
   } chcf_state_type;

   typedef struct packed {
      chcf_mode_type      mode;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic        [15:0] zero_angle;
   } chcf_req_type;

   typedef struct packed {
      logic signed [15:0] heading_rel;
      logic        [15:0] heading_abs;
   } chcf_rsp_type;

endpackage

`default_nettype wire

[rtl/core/compass_heading_circular_filter.sv]
`default_nettype none

// Compass heading with circular low-pass filter. Each request carries a mode and a raw X/Y
// magnetometer sample and yields exactly one response: the filtered heading relative to the
// zero point and the unfiltered heading (with declination) of the latest stored sample, both
// as 16-bit binary angles. The heading comes from a vectoring CORDIC that runs one
// micro-rotation per clock on a single shared shift-add unit. An accepted request passes
// through ST_PREP, CORDIC_STEPS rounds of ST_ITER, then ST_ROUND, ST_DELTA, ST_MUL, ST_DONE;
// req_ready stays low until ST_IDLE, which is entered as the response is registered. A new
// request is taken while a response still waits in the output register; ST_DONE holds only
// while that register is full and not being read. The user must write configuration via
// csr_we / csr_index / csr_wdata only while the block is idle; it is not enforced.
module compass_heading_circular_filter #(
   parameter int ANGLE_BITS   = chcf_pkg::ANGLE_BITS_DEFAULT,
   parameter int CORDIC_STEPS = chcf_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire chcf_pkg::chcf_req_type          req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output chcf_pkg::chcf_rsp_type               rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [chcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [chcf_pkg::CSR_W-1:0]      csr_wdata
);

   import chcf_pkg::*;

   localparam int StepW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [32:0] StepHalf = 33'(1) << (31 - ANGLE_BITS);
   localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);
   localparam logic [ANGLE_BITS-1:0] HalfTurn = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

   chcf_state_type state_ff, state_in;

   logic signed [15:0]       offset_x_ff, offset_x_in;
   logic signed [15:0]       offset_y_ff, offset_y_in;
   logic        [15:0]       decl_ff, decl_in;
   logic        [CSR_W-1:0]  alpha_ff, alpha_in;

   logic        [15:0]       zero_offset_ff, zero_offset_in;
   logic        [15:0]       filt_ff, filt_in;
   logic                     have_ff, have_in;
   logic signed [16:0]       last_x_ff, last_x_in;
   logic signed [16:0]       last_y_ff, last_y_in;

   chcf_mode_type            mode_ff, mode_in;
   logic        [15:0]       zero_angle_ff, zero_angle_in;
   logic signed [XY_W-1:0]   x_ff, x_in;
   logic signed [XY_W-1:0]   y_ff, y_in;
   logic [ANGLE_BITS-1:0]    z_ff, z_in;
   logic [StepW-1:0]         cnt_ff, cnt_in;
   logic                     zvec_ff, zvec_in;
   logic        [15:0]       habs_ff, habs_in;
   logic        [15:0]       rel_ff, rel_in;
   logic signed [15:0]       delta_ff, delta_in;
   logic signed [15:0]       step_ff, step_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   chcf_rsp_type             rsp_ff, rsp_in;

   logic signed [XY_W-1:0]   xe, ye, dx, dy;
   logic [32:0]              atan_sum;
   logic [ANGLE_BITS-1:0]    zstep;
   logic [15:0]              hd;
   logic signed [33:0]       prod_full;
   logic                     out_free;

   generate
      if (ANGLE_BITS > 16) begin : g_round
         localparam int RndSh = ANGLE_BITS - 16;
         logic [ANGLE_BITS:0] z_rnd;
         assign z_rnd = {1'b0, z_ff} + ((ANGLE_BITS + 1)'(1) << (RndSh - 1));
         assign hd    = z_rnd[RndSh +: 16];
      end else begin : g_pad
         assign hd = 16'(z_ff) << (16 - ANGLE_BITS);
      end
   endgenerate

   assign xe = {{(XY_W-25){last_x_ff[16]}}, last_x_ff, 8'd0};
   assign ye = {{(XY_W-25){last_y_ff[16]}}, last_y_ff, 8'd0};
   assign dx = y_ff >>> cnt_ff;
   assign dy = x_ff >>> cnt_ff;
   assign atan_sum  = {1'b0, ATAN_TURN32[ATAN_IDX_W'(cnt_ff)]} + StepHalf;
   assign zstep     = ANGLE_BITS'(atan_sum >> (32 - ANGLE_BITS));
   assign prod_full = $signed({1'b0, alpha_ff}) * delta_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      offset_x_in    = offset_x_ff;
      offset_y_in    = offset_y_ff;
      decl_in        = decl_ff;
      alpha_in       = alpha_ff;
      zero_offset_in = zero_offset_ff;
      filt_in        = filt_ff;
      have_in        = have_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      mode_in        = mode_ff;
      zero_angle_in  = zero_angle_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      cnt_in         = cnt_ff;
      zvec_in        = zvec_ff;
      habs_in        = habs_ff;
      rel_in         = rel_ff;
      delta_in       = delta_ff;
      step_in        = step_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         unique case (csr_index)
            CSR_OFFSET_X:     offset_x_in = csr_wdata[15:0];
            CSR_OFFSET_Y:     offset_y_in = csr_wdata[15:0];
            CSR_DECLINATION:  decl_in     = csr_wdata[15:0];
            CSR_FILTER_ALPHA: alpha_in    = csr_wdata;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_data.mode;
               zero_angle_in = req_data.zero_angle;
               if (req_data.mode == MODE_SAMPLE) begin
                  last_x_in = {req_data.raw_x[15], req_data.raw_x}
                            - {offset_x_ff[15], offset_x_ff};
                  last_y_in = {req_data.raw_y[15], req_data.raw_y}
                            - {offset_y_ff[15], offset_y_ff};
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            zvec_in = (last_x_ff == '0) && (last_y_ff == '0);
            cnt_in  = '0;
            if (xe < 0) begin
               x_in = -xe;
               y_in = -ye;
               z_in = HalfTurn;
            end else begin
               x_in = xe;
               y_in = ye;
               z_in = '0;
            end
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (y_ff > 0) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + zstep;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - zstep;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            habs_in  = (zvec_ff ? 16'd0 : hd) + decl_ff;
            state_in = ST_DELTA;
         end
         ST_DELTA: begin
            rel_in   = habs_ff - zero_offset_ff;
            delta_in = habs_ff - zero_offset_ff - filt_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            step_in  = prod_full[31:16];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               unique case (mode_ff)
                  MODE_SAMPLE: begin
                     if (!have_ff) begin
                        filt_in = rel_ff;
                        have_in = 1'b1;
                     end else begin
                        filt_in = filt_ff + step_ff;
                     end
                  end
                  MODE_SET_ZERO: begin
                     zero_offset_in = habs_ff;
                     filt_in        = '0;
                     have_in        = 1'b1;
                  end
                  MODE_CLEAR_ZERO: begin
                     zero_offset_in = '0;
                     filt_in        = '0;
                     have_in        = 1'b0;
                  end
                  MODE_LOAD_ZERO: begin
                     zero_offset_in = zero_angle_ff;
                  end
               endcase
               rsp_in.heading_rel = filt_in;
               rsp_in.heading_abs = habs_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff    <= '0;
         offset_y_ff    <= '0;
         decl_ff        <= '0;
         alpha_ff       <= ALPHA_RESET;
         zero_offset_ff <= '0;
         filt_ff        <= '0;
         have_ff        <= 1'b0;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         offset_x_ff    <= offset_x_in;
         offset_y_ff    <= offset_y_in;
         decl_ff        <= decl_in;
         alpha_ff       <= alpha_in;
         zero_offset_ff <= zero_offset_in;
         filt_ff        <= filt_in;
         have_ff        <= have_in;
         last_x_ff      <= last_x_in;
         last_y_ff      <= last_y_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      zero_angle_ff <= zero_angle_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      cnt_ff        <= cnt_in;
      zvec_ff       <= zvec_in;
      habs_ff       <= habs_in;
      rel_ff        <= rel_in;
      delta_ff      <= delta_in;
      step_ff       <= step_in;
      rsp_ff        <= rsp_in;
   end

endmodule

`default_nettype wire

[rtl/core/chcf_checker.sv]
`default_nettype none

module chcf_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire chcf_pkg::chcf_req_type          req_data,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire chcf_pkg::chcf_rsp_type          rsp_data,
   input wire logic                            csr_we,
   input wire logic [chcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input wire logic [chcf_pkg::CSR_W-1:0]      csr_wdata
);

   logic unused_ok;
   assign unused_ok = ^{req_data, csr_we, csr_index, csr_wdata};

   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without work in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind compass_heading_circular_filter chcf_checker u_chcf_checker (.*);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
   import chcf_pkg::*;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ARCTAN_TURNS [0:15] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 170;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AT      = 400;
   localparam int TAIL_CYCLES  = 30;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   chcf_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   chcf_rsp_type rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_OFFSET_X;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // predicted block state and register copies
   logic signed [15:0] cfg_off_x = '0;
   logic signed [15:0] cfg_off_y = '0;
   logic        [15:0] cfg_decl = '0;
   logic        [16:0] cfg_alpha = ALPHA_RESET;
   logic        [15:0] zero_ref = '0;
   logic        [15:0] filt = '0;
   logic               primed = 1'b0;
   int                 last_dx = 0;
   int                 last_dy = 0;

   chcf_req_type pending_reqs [$];
   chcf_rsp_type heading_q [$];
   chcf_rsp_type want;

   bit no_idle = 1'b0;
   bit held_once = 1'b0;
   int hold_left = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int send_roll;
   int recv_roll;
   int error_count = 0;
   int req_count = 0;
   int rsp_count = 0;
   int sample_count = 0;
   int zero_cmd_count = 0;
   int settings_count = 0;
   int phase;

   compass_heading_circular_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [15:0] cordic_angle(int xi, int yi);
      longint      x;
      longint      y;
      longint      dx;
      longint      dy;
      logic [31:0] z;
      logic [31:0] step;
      int          i;
      if (xi == 0 && yi == 0) return 16'h0000;
      x = longint'(xi) * 256;
      y = longint'(yi) * 256;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000;
      end
      for (i = 0; i < 16; i++) begin
         step = (ARCTAN_TURNS[i] + 32'h8000) >> 16;
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx;
            y = y - dy;
            z = z + step;
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - step;
         end
      end
      return z[15:0];
   endfunction

   function automatic chcf_rsp_type predict_heading(chcf_req_type r);
      chcf_rsp_type res;
      logic [15:0]  habs;
      logic [15:0]  rel;
      logic [15:0]  diff;
      longint       prod;
      if (r.mode == MODE_SAMPLE) begin
         last_dx = int'($signed(r.raw_x)) - int'(cfg_off_x);
         last_dy = int'($signed(r.raw_y)) - int'(cfg_off_y);
      end
      habs = cordic_angle(last_dx, last_dy) + cfg_decl;
      case (r.mode)
         MODE_SAMPLE: begin
            rel = habs - zero_ref;
            if (!primed) begin
               filt = rel;
               primed = 1'b1;
            end else begin
               diff = rel - filt;
               prod = longint'(cfg_alpha) * longint'($signed(diff));
               filt = filt + 16'(prod >>> 16);
            end
            sample_count++;
         end
         MODE_SET_ZERO: begin
            zero_ref = habs;
            filt = '0;
            primed = 1'b1;
            zero_cmd_count++;
         end
         MODE_CLEAR_ZERO: begin
            zero_ref = '0;
            filt = '0;
            primed = 1'b0;
            zero_cmd_count++;
         end
         MODE_LOAD_ZERO: begin
            zero_ref = r.zero_angle;
            zero_cmd_count++;
         end
         default: begin
         end
      endcase
      res.heading_rel = filt;
      res.heading_abs = habs;
      return res;
   endfunction

   function automatic chcf_req_type make_req(chcf_mode_type m, logic [15:0] x, logic [15:0] y,
                                             logic [15:0] z);
      chcf_req_type r;
      r.mode = m;
      r.raw_x = x;
      r.raw_y = y;
      r.zero_angle = z;
      return r;
   endfunction

   function automatic logic [15:0] pick_raw(logic [15:0] offset);
      logic [15:0] v;
      case ($urandom_range(0, 9))
         5: v = 16'($urandom_range(0, 8)) - 16'd4;
         6: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         7: v = offset;
         8: v = offset + 16'($urandom_range(0, 6)) - 16'd3;
         9: v = 16'($urandom_range(0, 512)) - 16'd256;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   function automatic chcf_req_type random_req();
      int            roll;
      chcf_mode_type m;
      roll = $urandom_range(0, 99);
      if (roll < 70) m = MODE_SAMPLE;
      else if (roll < 80) m = MODE_SET_ZERO;
      else if (roll < 88) m = MODE_CLEAR_ZERO;
      else m = MODE_LOAD_ZERO;
      return make_req(m, pick_raw(cfg_off_x), pick_raw(cfg_off_y), 16'($urandom));
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic write_settings(logic [15:0] ox, logic [15:0] oy, logic [15:0] decl,
                                 logic [16:0] alpha);
      write_reg(CSR_OFFSET_X, {ox[15], ox});
      write_reg(CSR_OFFSET_Y, {oy[15], oy});
      write_reg(CSR_DECLINATION, {decl[15], decl});
      write_reg(CSR_FILTER_ALPHA, alpha);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_off_x = ox;
      cfg_off_y = oy;
      cfg_decl = decl;
      cfg_alpha = alpha;
      settings_count++;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || heading_q.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) begin
            heading_q.push_back(predict_heading(req_data));
            req_count++;
         end
         send_roll = $urandom_range(0, 99);
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!no_idle && send_roll < 18) begin
            req_valid <= 1'b0;
         end else if (!no_idle && send_roll == 18) begin
            send_gap = $urandom_range(5, 30);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (heading_q.size() == 0) begin
               $error("response with no request outstanding: rel %0d abs %0d",
                      rsp_data.heading_rel, rsp_data.heading_abs);
               error_count++;
            end else begin
               want = heading_q.pop_front();
               if (rsp_data.heading_rel !== want.heading_rel) begin
                  $error("heading_rel mismatch: expected %0d, actual %0d",
                         want.heading_rel, rsp_data.heading_rel);
                  error_count++;
               end
               if (rsp_data.heading_abs !== want.heading_abs) begin
                  $error("heading_abs mismatch: expected %0d, actual %0d",
                         want.heading_abs, rsp_data.heading_abs);
                  error_count++;
               end
            end
         end
         recv_roll = $urandom_range(0, 99);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held_once && rsp_count >= HOLD_AT) begin
            // hold off long enough for the block to back up into the request side
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && recv_roll < 18) begin
            rsp_ready <= 1'b0;
         end else if (!no_idle && recv_roll == 18) begin
            recv_gap = $urandom_range(5, 30);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      pending_reqs.push_back(make_req(MODE_SET_ZERO, 16'h1234, 16'hABCD, 16'hFFFF));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h7FFF, 16'h0000, 16'hFFFF));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h8000, 16'h0000, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h0000, 16'h7FFF, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h0000, 16'h8000, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h8000, 16'h8000, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000));
      pending_reqs.push_back(make_req(MODE_LOAD_ZERO, 16'h8000, 16'h7FFF, 16'hFFFF));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h0001, 16'h0001, 16'h0000));
      pending_reqs.push_back(make_req(MODE_LOAD_ZERO, 16'h7FFF, 16'h8000, 16'h0000));
      pending_reqs.push_back(make_req(MODE_CLEAR_ZERO, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'hFFFB, 16'h0007, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h0005, 16'hFFF9, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SET_ZERO, 16'h0000, 16'h0000, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h0005, 16'hFFF9, 16'h0000));
      pending_reqs.push_back(make_req(MODE_LOAD_ZERO, 16'h0000, 16'h0000, 16'h8000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h8000, 16'h0001, 16'h0000));
      pending_reqs.push_back(make_req(MODE_CLEAR_ZERO, 16'h0000, 16'h0000, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SET_ZERO, 16'h0000, 16'h0000, 16'h0000));
      pending_reqs.push_back(make_req(MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000));
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_settings(16'h0000, 16'h0000, 16'h0000, 17'd65536);
            1: write_settings(16'h8000, 16'h7FFF, 16'h7FFF, 17'd0);
            2: write_settings(16'h7FFF, 16'h8000, 16'h8000, 17'd131071);
            3: write_settings(16'($urandom_range(0, 400)) - 16'd200,
                              16'($urandom_range(0, 400)) - 16'd200, 16'($urandom), 17'd1);
            4: write_settings(16'($urandom), 16'($urandom), 16'($urandom),
                              17'($urandom_range(0, 131071)));
            5: write_settings(16'($urandom), 16'($urandom), 16'($urandom), ALPHA_RESET);
            6: write_settings(16'($urandom), 16'($urandom), 16'($urandom),
                              17'($urandom_range(0, 65536)));
            default: write_settings(16'($urandom), 16'($urandom), 16'($urandom), 17'd32768);
         endcase
         no_idle = (phase == 5);
         repeat (PHASE_ITEMS) pending_reqs.push_back(random_req());
         drain();
      end
      no_idle = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (heading_q.size() != 0) begin
         $error("%0d responses never arrived", heading_q.size());
         error_count++;
      end
      $display("Covered %0d requests (%0d samples, %0d zero commands) over %0d register settings",
               req_count, sample_count, zero_cmd_count, settings_count + 1);
      $display("with random stalls on both sides and one %0d-cycle response hold",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/chcf_pkg.sv
rtl/core/compass_heading_circular_filter.sv
rtl/core/chcf_checker.sv
bench/tb.sv
